/* rtl/tscb_pkg.sv */
// Types, codes and the control program of the text screen cursor buffer.
package tscb_pkg;

  // Field widths fixed by the command and result words
  localparam int KIND_W   = 4;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register reset values, store fill character and the null character
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 6'd24;
  localparam logic [COL_W-1:0]  WIDTH_RST  = 8'd80;
  localparam logic [CHAR_W-1:0] FILL_RST   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_HOME  = 4'd0,
    KIND_FWD   = 4'd1,
    KIND_BACK  = 4'd2,
    KIND_UP    = 4'd3,
    KIND_DOWN  = 4'd4,
    KIND_END   = 4'd5,
    KIND_MOVE  = 4'd6,
    KIND_WRITE = 4'd7,
    KIND_READ  = 4'd8,
    KIND_CLEAR = 4'd9
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NUL   = 2'd2
  } status_e;

  // Program steps
  typedef enum logic [3:0] {
    PC_INIT, PC_IDLE, PC_GEO, PC_PREP, PC_HOME, PC_FWD, PC_BACK, PC_UP,
    PC_DOWN, PC_END, PC_MOVE, PC_WRITE, PC_CLEAR, PC_READ, PC_EMIT
  } pc_e;

  // Sequencing of a step
  typedef enum logic [2:0] {
    JMP_GOTO, JMP_DISPATCH, JMP_WAIT_IN, JMP_WAIT_OUT, JMP_LOOP
  } jmp_e;

  // Cursor operation of a step
  typedef enum logic [3:0] {
    CUR_HOLD, CUR_ZERO, CUR_CLAMP, CUR_FWD, CUR_BACK, CUR_UP, CUR_DOWN,
    CUR_LAST, CUR_MOVE
  } cur_op_e;

  // Store operation of a step
  typedef enum logic [2:0] {
    MEM_NONE, MEM_INIT, MEM_FILL, MEM_WRITE, MEM_READ
  } mem_op_e;

  // One control word
  typedef struct packed {
    logic    take;
    jmp_e    jmp;
    pc_e     tgt;
    cur_op_e cur;
    mem_op_e mem;
    logic    ld_prod;
    logic    mul_tgt;
    logic    ld_size;
    logic    emit;
  } ctrl_t;

  // Conditions the sequencer branches on
  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic fill_last;
  } cond_t;

  // Control program
  function automatic ctrl_t ucode(pc_e pc);
    ctrl_t c;
    c = '{take: 1'b0, jmp: JMP_GOTO, tgt: PC_READ, cur: CUR_HOLD, mem: MEM_NONE,
          ld_prod: 1'b0, mul_tgt: 1'b0, ld_size: 1'b0, emit: 1'b0};
    case (pc)
      PC_INIT: begin
        c.mem = MEM_INIT;
        c.jmp = JMP_LOOP;
        c.tgt = PC_IDLE;
      end
      PC_IDLE: begin
        c.take = 1'b1;
        c.jmp  = JMP_WAIT_IN;
        c.tgt  = PC_GEO;
      end
      PC_GEO: begin
        c.ld_prod = 1'b1;
        c.tgt     = PC_PREP;
      end
      PC_PREP: begin
        c.ld_size = 1'b1;
        c.ld_prod = 1'b1;
        c.mul_tgt = 1'b1;
        c.cur     = CUR_CLAMP;
        c.jmp     = JMP_DISPATCH;
      end
      PC_HOME:  c.cur = CUR_ZERO;
      PC_FWD:   c.cur = CUR_FWD;
      PC_BACK:  c.cur = CUR_BACK;
      PC_UP:    c.cur = CUR_UP;
      PC_DOWN:  c.cur = CUR_DOWN;
      PC_END:   c.cur = CUR_LAST;
      PC_MOVE:  c.cur = CUR_MOVE;
      PC_WRITE: c.mem = MEM_WRITE;
      PC_CLEAR: begin
        c.mem = MEM_FILL;
        c.cur = CUR_ZERO;
        c.jmp = JMP_LOOP;
      end
      PC_READ: begin
        c.mem = MEM_READ;
        c.tgt = PC_EMIT;
      end
      PC_EMIT: begin
        c.emit = 1'b1;
        c.jmp  = JMP_WAIT_OUT;
        c.tgt  = PC_IDLE;
      end
      default: c.tgt = PC_IDLE;
    endcase
    return c;
  endfunction

  // First step of each command kind; unused kinds act as home
  function automatic pc_e dispatch(logic [KIND_W-1:0] kind);
    pc_e pc;
    case (kind)
      KIND_FWD:              pc = PC_FWD;
      KIND_BACK:             pc = PC_BACK;
      KIND_UP:               pc = PC_UP;
      KIND_DOWN:             pc = PC_DOWN;
      KIND_END:              pc = PC_END;
      KIND_MOVE, KIND_READ:  pc = PC_MOVE;
      KIND_WRITE:            pc = PC_WRITE;
      KIND_CLEAR:            pc = PC_CLEAR;
      default:               pc = PC_HOME;
    endcase
    return pc;
  endfunction

endpackage

/* rtl/tscb_if.sv */
// Handshake channels of the text screen cursor buffer: command, result, register write.
interface tscb_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tscb_pkg::KIND_W-1:0] kind;
  logic [tscb_pkg::ROW_W-1:0]  target_row;
  logic [tscb_pkg::COL_W-1:0]  target_col;
  logic [tscb_pkg::CHAR_W-1:0] char_value;

  modport source (output valid, kind, target_row, target_col, char_value, input ready);
  modport sink   (input valid, kind, target_row, target_col, char_value, output ready);
endinterface

interface tscb_res_if;
  logic                          valid;
  logic                          ready;
  logic [tscb_pkg::CHAR_W-1:0]   read_char;
  logic [tscb_pkg::POS_W-1:0]    cursor_pos;
  logic [tscb_pkg::STATUS_W-1:0] status;

  modport source (output valid, read_char, cursor_pos, status, input ready);
  modport sink   (input valid, read_char, cursor_pos, status, output ready);
endinterface

interface tscb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tscb_pkg::CFG_IDX_W-1:0]  index;
  logic [tscb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tscb_seq.sv */
// Program counter and control store of the text screen cursor buffer.
module tscb_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tscb_pkg::KIND_W-1:0] kind_i,
  input  tscb_pkg::cond_t             cond_i,
  output tscb_pkg::ctrl_t             ctrl_o
);

  tscb_pkg::pc_e pc_q, pc_d;

  // Fetch the control word of the current step
  assign ctrl_o = tscb_pkg::ucode(pc_q);

  // Pick the next step
  always_comb begin
    case (ctrl_o.jmp)
      tscb_pkg::JMP_GOTO:     pc_d = ctrl_o.tgt;
      tscb_pkg::JMP_DISPATCH: pc_d = tscb_pkg::dispatch(kind_i);
      tscb_pkg::JMP_WAIT_IN:  pc_d = cond_i.in_fire   ? ctrl_o.tgt : pc_q;
      tscb_pkg::JMP_WAIT_OUT: pc_d = cond_i.out_free  ? ctrl_o.tgt : pc_q;
      tscb_pkg::JMP_LOOP:     pc_d = cond_i.fill_last ? ctrl_o.tgt : pc_q;
      default:                pc_d = tscb_pkg::PC_IDLE;
    endcase
  end

  // Hold the step counter; start with the store clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tscb_pkg::PC_INIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/text_screen_cursor_buffer_unit.sv */
// Top level of the text screen cursor buffer: datapath, cell store and result register.
// Character screen of up to MAX_ROWS by MAX_COLS cells with a linear row-major cursor.
// A command word is taken, then a short control program runs: one step forms the
// screen size on the shared multiplier, one forms the target offset and clamps the
// cursor, one applies the command, one reads the cell under the cursor from the
// store, and one loads the result register. A clear walks the active area one cell a
// cycle. The next command is taken while a result still waits in the output register.
// After reset the store is filled with the space character one cell a cycle, over all
// MAX_ROWS * MAX_COLS cells (4096 at the defaults), during which no command is taken;
// register writes are taken at any time, and writing the height or width homes the cursor.
module text_screen_cursor_buffer_unit #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tscb_cmd_if.sink    cmd_i,
  tscb_res_if.source  res_o,
  tscb_cfg_if.sink    cfg_i
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CURW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SZW   = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int MW    = RW + CW;

  tscb_pkg::ctrl_t ctrl;
  tscb_pkg::cond_t cond;

  // Registers
  logic [tscb_pkg::ROW_W-1:0]    height_q;
  logic [tscb_pkg::COL_W-1:0]    width_q;
  logic [tscb_pkg::KIND_W-1:0]   kind_q;
  logic [tscb_pkg::ROW_W-1:0]    trow_q;
  logic [tscb_pkg::COL_W-1:0]    tcol_q;
  logic [tscb_pkg::CHAR_W-1:0]   ch_q;
  logic [CURW-1:0]               cursor_q, cursor_d;
  tscb_pkg::status_e             status_q, status_d;
  logic [SZW-1:0]                prod_q, size_q, lrb_q;
  logic [CURW-1:0]               cnt_q;
  logic [tscb_pkg::CHAR_W-1:0]   rdata_q;
  logic                          res_valid_q;
  logic [tscb_pkg::CHAR_W-1:0]   res_char_q;
  logic [tscb_pkg::POS_W-1:0]    res_pos_q;
  tscb_pkg::status_e             res_status_q;

  // Datapath signals
  logic [RW-1:0]                 h_eff;
  logic [CW-1:0]                 w_eff;
  logic [RW-1:0]                 mul_a;
  logic [MW-1:0]                 mul_p;
  logic [SZW-1:0]                cur_x, w_x;
  logic                          coords_ok;
  logic                          in_fire, out_free, res_load, geo_wr;
  logic                          mem_we;
  logic [CURW-1:0]               mem_waddr;
  logic [tscb_pkg::CHAR_W-1:0]   mem_wdata;
  logic                          fill_last;
  logic [tscb_pkg::CHAR_W-1:0]   mem [CELLS];

  tscb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kind_i (kind_q),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  // Handshakes
  assign cmd_i.ready = ctrl.take;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = cmd_i.valid & ctrl.take;
  assign out_free    = !res_valid_q || res_o.ready;
  assign res_load    = ctrl.emit & out_free;
  assign geo_wr      = cfg_i.valid &&
                       (cfg_i.index == tscb_pkg::CFG_HEIGHT ||
                        cfg_i.index == tscb_pkg::CFG_WIDTH);

  assign cond = '{in_fire: in_fire, out_free: out_free, fill_last: fill_last};

  // Limit geometry to the store size
  always_comb begin
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_q) > MAX_ROWS) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(height_q);
    end
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_q) > MAX_COLS) begin
      w_eff = CW'(MAX_COLS);
    end else begin
      w_eff = CW'(width_q);
    end
  end

  // Shared multiplier: screen size, or row offset of the target
  assign mul_a = ctrl.mul_tgt ? RW'(trow_q - 6'd1) : h_eff;
  assign mul_p = {{CW{1'b0}}, mul_a} * {{RW{1'b0}}, w_eff};

  assign coords_ok = (trow_q != '0) && (32'(trow_q) <= 32'(h_eff)) &&
                     (tcol_q != '0) && (32'(tcol_q) <= 32'(w_eff));

  assign cur_x = SZW'(cursor_q);
  assign w_x   = SZW'(w_eff);

  // Next cursor and status
  always_comb begin
    cursor_d = cursor_q;
    status_d = status_q;
    case (ctrl.cur)
      tscb_pkg::CUR_HOLD:  cursor_d = cursor_q;
      tscb_pkg::CUR_ZERO:  cursor_d = '0;
      tscb_pkg::CUR_CLAMP: cursor_d = (cur_x >= prod_q) ? '0 : cursor_q;
      tscb_pkg::CUR_FWD:   cursor_d = (cur_x + SZW'(1) >= size_q) ? '0
                                      : CURW'(cur_x + SZW'(1));
      tscb_pkg::CUR_BACK:  cursor_d = (cursor_q == '0) ? CURW'(size_q - SZW'(1))
                                      : CURW'(cur_x - SZW'(1));
      tscb_pkg::CUR_UP:    cursor_d = (cur_x < w_x) ? CURW'(cur_x + lrb_q)
                                      : CURW'(cur_x - w_x);
      tscb_pkg::CUR_DOWN:  cursor_d = (cur_x >= lrb_q) ? CURW'(cur_x - lrb_q)
                                      : CURW'(cur_x + w_x);
      tscb_pkg::CUR_LAST:  cursor_d = CURW'(size_q - SZW'(1));
      tscb_pkg::CUR_MOVE: begin
        if (coords_ok) begin
          cursor_d = CURW'(prod_q + SZW'(8'(tcol_q - 8'd1)));
        end else begin
          status_d = tscb_pkg::ST_RANGE;
        end
      end
      default: cursor_d = cursor_q;
    endcase
    if (ctrl.mem == tscb_pkg::MEM_WRITE && ch_q == tscb_pkg::CHAR_NUL) begin
      status_d = tscb_pkg::ST_NUL;
    end
    if (in_fire) begin
      status_d = tscb_pkg::ST_OK;
    end
  end

  // Store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = ch_q;
    fill_last = 1'b0;
    case (ctrl.mem)
      tscb_pkg::MEM_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tscb_pkg::FILL_RST;
        fill_last = (cnt_q == CURW'(CELLS - 1));
      end
      tscb_pkg::MEM_FILL: begin
        mem_we    = 1'b1;
        fill_last = (SZW'(cnt_q) == size_q - SZW'(1));
      end
      tscb_pkg::MEM_WRITE: begin
        mem_we    = (ch_q != tscb_pkg::CHAR_NUL);
        mem_waddr = cursor_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Cell store, read under the cursor
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctrl.mem == tscb_pkg::MEM_READ) begin
      rdata_q <= mem[cursor_q];
    end
  end

  // Capture the command word and geometry products
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= cmd_i.kind;
      trow_q <= cmd_i.target_row;
      tcol_q <= cmd_i.target_col;
      ch_q   <= cmd_i.char_value;
    end
    if (ctrl.ld_prod) begin
      prod_q <= SZW'(mul_p);
    end
    if (ctrl.ld_size) begin
      size_q <= prod_q;
      lrb_q  <= prod_q - w_x;
    end
  end

  // Control state: registers, cursor, fill counter, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q     <= tscb_pkg::HEIGHT_RST;
      width_q      <= tscb_pkg::WIDTH_RST;
      cursor_q     <= '0;
      status_q     <= tscb_pkg::ST_OK;
      cnt_q        <= '0;
      res_valid_q  <= 1'b0;
      res_char_q   <= '0;
      res_pos_q    <= '0;
      res_status_q <= tscb_pkg::ST_OK;
    end else begin
      if (cfg_i.valid && cfg_i.index == tscb_pkg::CFG_HEIGHT) begin
        height_q <= cfg_i.data[tscb_pkg::ROW_W-1:0];
      end
      if (cfg_i.valid && cfg_i.index == tscb_pkg::CFG_WIDTH) begin
        width_q <= cfg_i.data;
      end
      cursor_q <= geo_wr ? '0 : cursor_d;
      status_q <= status_d;
      if (ctrl.mem == tscb_pkg::MEM_INIT || ctrl.mem == tscb_pkg::MEM_FILL) begin
        cnt_q <= fill_last ? '0 : cnt_q + CURW'(1);
      end
      if (res_load) begin
        res_valid_q  <= 1'b1;
        res_char_q   <= rdata_q;
        res_pos_q    <= tscb_pkg::POS_W'(cursor_q);
        res_status_q <= status_q;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.read_char  = res_char_q;
  assign res_o.cursor_pos = res_pos_q;
  assign res_o.status     = res_status_q;

  // Checks
  a_read_in_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.mem == tscb_pkg::MEM_READ |-> SZW'(cursor_q) < size_q)
    else $error("cursor outside the active area at read");

  a_no_write_when_taking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.take |-> !mem_we)
    else $error("store written while waiting for a command");

  a_cnt_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.take |-> cnt_q == '0)
    else $error("fill counter not cleared after a fill pass");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(ctrl.emit))
    else $error("result shown outside the emit step");

endmodule

/* dv/text_screen_result_checker.sv */
// Result checker for the text screen cursor buffer: mirrors the screen and compares each word.
`timescale 1ns / 100ps

module text_screen_result_checker #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  tscb_cmd_if  cmd_mon,
  tscb_res_if  res_mon,
  tscb_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;

  typedef struct packed {
    logic [tscb_pkg::CHAR_W-1:0]   read_char;
    logic [tscb_pkg::POS_W-1:0]    cursor_pos;
    logic [tscb_pkg::STATUS_W-1:0] status;
  } screen_result_t;

  // Mirror of the block's registers, cursor and cell store
  logic [tscb_pkg::ROW_W-1:0]  height_q;
  logic [tscb_pkg::COL_W-1:0]  width_q;
  logic [tscb_pkg::POS_W-1:0]  cursor_q;
  logic [tscb_pkg::CHAR_W-1:0] cells [CELLS];

  screen_result_t expected_results [$];
  screen_result_t want;
  int             fail_count;
  int             i;

  // Run one command against the mirror and form the word it returns
  task automatic step_screen(input logic [tscb_pkg::KIND_W-1:0] kind,
                             input logic [tscb_pkg::ROW_W-1:0] trow,
                             input logic [tscb_pkg::COL_W-1:0] tcol,
                             input logic [tscb_pkg::CHAR_W-1:0] ch,
                             output screen_result_t res);
    int rows;
    int cols;
    int size;
    int last_base;
    int cur;
    int n;
    logic [tscb_pkg::STATUS_W-1:0] st;
    rows = (height_q == 0) ? 1 : (int'(height_q) > MAX_ROWS) ? MAX_ROWS : int'(height_q);
    cols = (width_q == 0) ? 1 : (int'(width_q) > MAX_COLS) ? MAX_COLS : int'(width_q);
    size = rows * cols;
    last_base = (rows - 1) * cols;
    cur = int'(cursor_q);
    st = tscb_pkg::ST_OK;
    // Pull a stale cursor back into the active area
    if (cur >= size) cur = 0;
    case (kind)
      tscb_pkg::KIND_FWD:  cur = (cur + 1 >= size) ? 0 : cur + 1;
      tscb_pkg::KIND_BACK: cur = (cur == 0) ? size - 1 : cur - 1;
      tscb_pkg::KIND_UP:   cur = (cur < cols) ? cur + last_base : cur - cols;
      tscb_pkg::KIND_DOWN: cur = (cur >= last_base) ? cur - last_base : cur + cols;
      tscb_pkg::KIND_END:  cur = size - 1;
      tscb_pkg::KIND_MOVE, tscb_pkg::KIND_READ: begin
        if (trow >= 1 && int'(trow) <= rows && tcol >= 1 && int'(tcol) <= cols) begin
          cur = (int'(trow) - 1) * cols + (int'(tcol) - 1);
        end else begin
          st = tscb_pkg::ST_RANGE;
        end
      end
      tscb_pkg::KIND_WRITE: begin
        if (ch == tscb_pkg::CHAR_NUL) st = tscb_pkg::ST_NUL;
        else cells[cur] = ch;
      end
      tscb_pkg::KIND_CLEAR: begin
        for (n = 0; n < size; n++) cells[n] = ch;
        cur = 0;
      end
      // Home, and every unused kind
      default: cur = 0;
    endcase
    cursor_q = cur[tscb_pkg::POS_W-1:0];
    res.read_char  = cells[cur];
    res.cursor_pos = cur[tscb_pkg::POS_W-1:0];
    res.status     = st;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q = tscb_pkg::HEIGHT_RST;
      width_q  = tscb_pkg::WIDTH_RST;
      cursor_q = '0;
      for (i = 0; i < CELLS; i++) cells[i] = tscb_pkg::FILL_RST;
      expected_results.delete();
      fail_count = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Retire the oldest expected word against the one leaving the block
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: read_char %0d cursor_pos %0d status %0d",
                 res_mon.read_char, res_mon.cursor_pos, res_mon.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_mon.read_char !== want.read_char) begin
            $error("read_char expected %0d actual %0d", want.read_char, res_mon.read_char);
            fail_count++;
          end
          if (res_mon.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos expected %0d actual %0d", want.cursor_pos, res_mon.cursor_pos);
            fail_count++;
          end
          if (res_mon.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, res_mon.status);
            fail_count++;
          end
        end
      end
      // Geometry writes home the cursor; the block keeps no fill register, so the
      // fill index, like the remaining one, is unused
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          tscb_pkg::CFG_HEIGHT: begin
            height_q = cfg_mon.data[tscb_pkg::ROW_W-1:0];
            cursor_q = '0;
          end
          tscb_pkg::CFG_WIDTH: begin
            width_q  = cfg_mon.data[tscb_pkg::COL_W-1:0];
            cursor_q = '0;
          end
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        step_screen(cmd_mon.kind, cmd_mon.target_row, cmd_mon.target_col, cmd_mon.char_value,
                    want);
        expected_results.push_back(want);
      end
      pending_o    <= expected_results.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

/* dv/text_screen_cursor_buffer_unit_tb.sv */
// Testbench top for the text screen cursor buffer: command stimulus, stalls and the verdict.
`timescale 1ns / 100ps

module text_screen_cursor_buffer_unit_tb;

  typedef logic [tscb_pkg::KIND_W-1:0]     kind_t;
  typedef logic [tscb_pkg::ROW_W-1:0]      row_t;
  typedef logic [tscb_pkg::COL_W-1:0]      col_t;
  typedef logic [tscb_pkg::CHAR_W-1:0]     char_t;
  typedef logic [tscb_pkg::CFG_DATA_W-1:0] cfg_data_t;

  localparam int SCREEN_ROWS = 32;
  localparam int SCREEN_COLS = 128;
  localparam logic [tscb_pkg::CFG_IDX_W-1:0] CFG_FILL  = 2'd2;
  localparam logic [tscb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int     PHASES      = 11;
  localparam int     PHASE_ITEMS = 145;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic   clk_i;
  logic   rst_ni;
  int     fail_count;
  int     pending;
  bit     quiet = 1'b0;
  int     stall_left = 0;
  longint cycles = 0;
  // Active geometry as the block clamps it, for in-range coordinates
  int     rows_eff = int'(tscb_pkg::HEIGHT_RST);
  int     cols_eff = int'(tscb_pkg::WIDTH_RST);

  tscb_cmd_if cmd_ch ();
  tscb_res_if res_ch ();
  tscb_cfg_if cfg_ch ();

  text_screen_cursor_buffer_unit #(
    .MAX_ROWS(SCREEN_ROWS),
    .MAX_COLS(SCREEN_COLS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  text_screen_result_checker #(
    .MAX_ROWS(SCREEN_ROWS),
    .MAX_COLS(SCREEN_COLS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_mon     (cmd_ch),
    .res_mon     (res_ch),
    .cfg_mon     (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one; none during a quiet stretch
  function automatic int idle_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) < 3) stall_left <= idle_len();
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("text_screen_cursor_buffer_unit: mismatch");
      $finish;
    end
  end

  // Present one command word and hold it until taken; valid stays high for a follow-on
  task automatic send_cmd(input logic [tscb_pkg::KIND_W-1:0] k,
                          input logic [tscb_pkg::ROW_W-1:0] r,
                          input logic [tscb_pkg::COL_W-1:0] c,
                          input logic [tscb_pkg::CHAR_W-1:0] ch);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= k;
    cmd_ch.target_row <= r;
    cmd_ch.target_col <= c;
    cmd_ch.char_value <= ch;
    @(posedge clk_i);
    while (!(cmd_ch.valid && cmd_ch.ready)) @(posedge clk_i);
  endtask

  // Present one register write and hold it until taken
  task automatic write_reg(input logic [tscb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tscb_pkg::CFG_DATA_W-1:0] d);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk_i);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk_i);
  endtask

  // Drop the command side and wait for every expected word to come back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Set a new geometry while the block is idle; the block ignores the fill write
  task automatic reconfigure(input logic [tscb_pkg::ROW_W-1:0] hv,
                             input logic [tscb_pkg::COL_W-1:0] wv,
                             input logic [tscb_pkg::CHAR_W-1:0] fv, input bit spare);
    settle();
    write_reg(tscb_pkg::CFG_HEIGHT, cfg_data_t'(hv));
    write_reg(tscb_pkg::CFG_WIDTH, cfg_data_t'(wv));
    write_reg(CFG_FILL, fv);
    if (spare) write_reg(CFG_SPARE, cfg_data_t'($urandom));
    cfg_ch.valid <= 1'b0;
    rows_eff = (hv == 0) ? 1 : (int'(hv) > SCREEN_ROWS) ? SCREEN_ROWS : int'(hv);
    cols_eff = (wv == 0) ? 1 : (int'(wv) > SCREEN_COLS) ? SCREEN_COLS : int'(wv);
  endtask

  // One random command: mostly legal coordinates, some noise in every field
  task automatic random_cmd();
    int    p;
    kind_t k;
    row_t  r;
    col_t  c;
    char_t ch;
    p = $urandom_range(0, 99);
    if (p < 4) begin
      k = kind_t'($urandom_range(tscb_pkg::KIND_CLEAR + 1, (1 << tscb_pkg::KIND_W) - 1));
    end else if (p < 6) k = tscb_pkg::KIND_CLEAR;
    else if (p < 24) k = tscb_pkg::KIND_WRITE;
    else if (p < 38) k = tscb_pkg::KIND_READ;
    else if (p < 48) k = tscb_pkg::KIND_MOVE;
    else k = kind_t'($urandom_range(tscb_pkg::KIND_HOME, tscb_pkg::KIND_READ));
    if ($urandom_range(0, 3) != 0) begin
      r = row_t'($urandom_range(1, rows_eff));
      c = col_t'($urandom_range(1, cols_eff));
    end else begin
      r = row_t'($urandom);
      c = col_t'($urandom);
    end
    if (k == tscb_pkg::KIND_WRITE && $urandom_range(0, 9) == 0) ch = tscb_pkg::CHAR_NUL;
    else if (k == tscb_pkg::KIND_WRITE) ch = char_t'($urandom_range(1, 255));
    else ch = char_t'($urandom);
    send_cmd(k, r, c, ch);
  endtask

  initial begin
    int   phase;
    int   n;
    row_t hv;
    col_t wv;
    rst_ni            <= 1'b0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.kind       <= tscb_pkg::KIND_HOME;
    cmd_ch.target_row <= '0;
    cmd_ch.target_col <= '0;
    cmd_ch.char_value <= tscb_pkg::CHAR_NUL;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= tscb_pkg::CFG_HEIGHT;
    cfg_ch.data       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset contents, wraps, range errors, null write, unused kinds, clear
    send_cmd(tscb_pkg::KIND_READ, 6'd1, 8'd1, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_BACK, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_FWD, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_UP, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_DOWN, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_END, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_MOVE, 6'd24, 8'd80, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_MOVE, 6'd0, 8'd5, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_MOVE, 6'd25, 8'd1, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_MOVE, 6'd1, 8'd81, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_MOVE, 6'd63, 8'd255, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_WRITE, '0, '0, 8'hFF);
    send_cmd(tscb_pkg::KIND_WRITE, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_READ, 6'd24, 8'd80, 8'h01);
    send_cmd(tscb_pkg::KIND_READ, 6'd0, 8'd0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_HOME, 6'h3F, 8'hFF, 8'hFF);
    send_cmd(4'hF, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(kind_t'(tscb_pkg::KIND_CLEAR + 1), '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_CLEAR, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_READ, 6'd2, 8'd3, 8'hA5);

    // Single row: vertical motion leaves the cursor in place
    reconfigure(6'd1, 8'd8, 8'd0, 1'b0);
    send_cmd(tscb_pkg::KIND_FWD, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_UP, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_DOWN, '0, '0, tscb_pkg::CHAR_NUL);
    send_cmd(tscb_pkg::KIND_BACK, '0, '0, tscb_pkg::CHAR_NUL);

    // Random phases across geometries, extremes and clamped values among them
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin hv = 6'd1;  wv = 8'd1;   end
        1:       begin hv = 6'd0;  wv = 8'd0;   end
        2:       begin hv = 6'd32; wv = 8'd128; end
        3:       begin hv = 6'd63; wv = 8'd255; end
        4:       begin hv = 6'd3;  wv = 8'd200; end
        5:       begin hv = 6'd40; wv = 8'd3;   end
        6:       begin hv = 6'd5;  wv = 8'd1;   end
        7: begin
          hv = row_t'($urandom_range(0, 63));
          wv = col_t'($urandom_range(0, 255));
        end
        default: begin
          hv = row_t'($urandom_range(1, 8));
          wv = col_t'($urandom_range(1, 16));
        end
      endcase
      quiet = 1'b0;
      reconfigure(hv, wv, (phase == 3) ? 8'hFF : char_t'($urandom), phase % 3 == 0);
      quiet = (phase % 4 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) random_cmd();
    end

    quiet = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_screen_cursor_buffer_unit: match");
    end else begin
      $display("text_screen_cursor_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule
